// ===== rtl/tlst_pkg.sv =====
// ----------------------------------------------------------------------------
// tlst_pkg: shared types and constants of the track length and speed tracker
// Holds the beat layouts of both channels, the request and response groups of
// the iterative arithmetic units, the register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tlst_pkg;

	// Field widths
	localparam int POS_W    = 24;
	localparam int MAG_W    = 24;   // largest coordinate difference is 2^24-1
	localparam int SQ_W     = 2 * MAG_W;
	localparam int RAD_W    = 50;   // sum of three squares
	localparam int ROOT_W   = RAD_W / 2;
	localparam int STAMP_W  = 32;
	localparam int LEN_W    = 40;
	localparam int SPD_W    = 32;
	localparam int BOX_W    = 23;
	localparam int FRAC_W   = 16;

	// Divider geometry
	localparam int NUM_W        = LEN_W + FRAC_W;
	localparam int DIV_CNT_W    = $clog2(NUM_W + 1);
	localparam int SPD_STEPS    = ROOT_W + FRAC_W;
	localparam int MEAN_STEPS   = NUM_W;
	localparam int ROOT_CNT_W   = $clog2(ROOT_W + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 2'd2;

	localparam logic [BOX_W-1:0] BOX_RESET = {BOX_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
	localparam logic [SPD_W-1:0] SPD_MAX   = {SPD_W{1'b1}};

	// Input beat
	typedef struct packed {
		logic                      start_track;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic        [STAMP_W-1:0] stamp;
	} point_t;

	// Result beat
	typedef struct packed {
		logic               visible;
		logic [LEN_W-1:0]   path_length;
		logic [SPD_W-1:0]   peak_speed;
		logic [SPD_W-1:0]   mean_speed;
		logic [STAMP_W-1:0] elapsed;
		logic               bad_step;
	} result_t;

	// Square root unit
	typedef struct packed {
		logic             go;
		logic [RAD_W-1:0] radicand;
	} sqrt_cmd_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	// Divider unit: dividend is aligned to the top, steps counts live bits
	typedef struct packed {
		logic                 go;
		logic [NUM_W-1:0]     dividend;
		logic [STAMP_W-1:0]   divisor;
		logic [DIV_CNT_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [SPD_W-1:0] quot;
	} div_rsp_t;

	// Sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_SUM,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_PATH,
		ST_SPD_GO,
		ST_SPD_WAIT,
		ST_MEAN_CHK,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_OUT
	} tlst_state_t;

endpackage

`default_nettype wire

// ===== rtl/tlst_sqrt.sv =====
// ----------------------------------------------------------------------------
// tlst_sqrt: iterative integer square root
// Digit-by-digit floor square root, two radicand bits per cycle, one
// compare and subtract per step; done pulses for one cycle with the root.
// ----------------------------------------------------------------------------
`default_nettype none

module tlst_sqrt (
	input  wire               clk,
	input  wire               arst_n,
	input  tlst_pkg::sqrt_cmd_t cmd,
	output tlst_pkg::sqrt_rsp_t rsp
);
	import tlst_pkg::*;

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W:0]       rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [ROOT_W+2:0] rem_shift;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rest;
	logic              fits;

	// Bring down the next radicand pair and test the trial term
	always_comb begin
		rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial     = {1'b0, root_q, 2'b01};
		rest      = rem_shift - trial;
		fits      = (rem_shift >= trial);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ROOT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= ROOT_CNT_W'(ROOT_W);
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rest[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end else if (cmd.go) begin
			rad_q  <= cmd.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

`default_nettype wire

// ===== rtl/tlst_div.sv =====
// ----------------------------------------------------------------------------
// tlst_div: shared iterative divider
// Restoring division, one quotient bit per cycle; the quotient saturates to
// the speed width. Serves both segment speed and mean speed.
// ----------------------------------------------------------------------------
`default_nettype none

module tlst_div (
	input  wire                clk,
	input  wire                arst_n,
	input  tlst_pkg::div_cmd_t cmd,
	output tlst_pkg::div_rsp_t rsp
);
	import tlst_pkg::*;

	logic [NUM_W-1:0]     num_q;
	logic [NUM_W-1:0]     quot_q;
	logic [STAMP_W-1:0]   rem_q;
	logic [STAMP_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [STAMP_W:0] trial;
	logic [STAMP_W:0] diff;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
		end else if (cmd.go) begin
			num_q  <= cmd.dividend;
			dvs_q  <= cmd.divisor;
			quot_q <= '0;
			rem_q  <= '0;
		end
	end

	// Saturate to the speed width
	assign rsp.done = done_q;
	assign rsp.quot = (|quot_q[NUM_W-1:SPD_W]) ? SPD_MAX : quot_q[SPD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/track_length_speed_tracker.sv =====
// ----------------------------------------------------------------------------
// track_length_speed_tracker: polyline path length and speed tracker
// Follows a track of timestamped 3D points, adding segment lengths into a
// saturating path length and keeping the peak and mean speeds in Q16.16.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+-------------------------
//   point    | point_valid / point_stall  | point_t  (in)
//   result   | result_valid / result_stall| result_t (out)
//   cfg      | cfg_we, cfg_index          | cfg_data (box limits)
//
// A continuing point is squared axis by axis on one 24x24 multiplier, then
// passes the square root unit and the shared divider (segment, mean speed).
// A bad time step skips the speed division, zero elapsed time the mean one;
// a track start goes straight to its result. point_stall is high from
// acceptance until the result is loaded; a stalled result holds the
// sequencer in its last state. Reset clears the track state and sets every
// box limit to its maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module track_length_speed_tracker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                point_valid,
	output logic                               point_stall,
	input  tlst_pkg::point_t                   point,
	output logic                               result_valid,
	input  wire                                result_stall,
	output tlst_pkg::result_t                  result,
	input  wire                                cfg_we,
	input  wire  [tlst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [tlst_pkg::BOX_W-1:0]         cfg_data
);
	import tlst_pkg::*;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	tlst_state_t state_q, state_d;

	logic [BOX_W-1:0] box_x_q, box_y_q, box_z_q;

	point_t             item_q;
	logic [POS_W-1:0]   prev_x_q, prev_y_q, prev_z_q;
	logic [STAMP_W-1:0] prev_stamp_q;
	logic [STAMP_W-1:0] first_q;
	logic [LEN_W-1:0]   length_q;
	logic [SPD_W-1:0]   peak_q;
	logic [SPD_W-1:0]   mean_q;
	logic               bad_q;
	logic               have_prev_q;

	logic [1:0]         ax_q;
	logic [SQ_W-1:0]    prod_s1;
	logic [RAD_W-1:0]   sum_q;
	logic [ROOT_W-1:0]  seg_q;

	result_t            result_q;
	logic               result_valid_q;

	logic               accept;
	logic               new_track;
	logic               out_load;
	logic signed [POS_W:0] diff;
	logic [MAG_W-1:0]   mag;
	logic [STAMP_W-1:0] dtu;
	logic [STAMP_W-1:0] elapsed;
	logic               step_bad;
	logic [LEN_W:0]     len_sum;
	logic               visible;

	sqrt_cmd_t sqrt_cmd;
	sqrt_rsp_t sqrt_rsp;
	div_cmd_t  div_cmd;
	div_rsp_t  div_rsp;

	tlst_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (sqrt_cmd),
		.rsp    (sqrt_rsp)
	);

	tlst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	// Handshake terms
	assign accept    = point_valid && !point_stall;
	assign new_track = point.start_track || !have_prev_q;

	// Difference on the selected axis, then its magnitude
	always_comb begin
		case (ax_q)
			AXIS_X:  diff = {item_q.pos_x[POS_W-1], item_q.pos_x}
				- {prev_x_q[POS_W-1], prev_x_q};
			AXIS_Y:  diff = {item_q.pos_y[POS_W-1], item_q.pos_y}
				- {prev_y_q[POS_W-1], prev_y_q};
			AXIS_Z:  diff = {item_q.pos_z[POS_W-1], item_q.pos_z}
				- {prev_z_q[POS_W-1], prev_z_q};
			default: diff = '0;
		endcase
		mag = diff[POS_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
	end

	// Time terms, path sum and box test
	always_comb begin
		dtu      = item_q.stamp - prev_stamp_q;
		elapsed  = item_q.stamp - first_q;
		step_bad = (dtu == '0) || dtu[STAMP_W-1];
		len_sum  = {1'b0, length_q} + (LEN_W+1)'(seg_q);
		visible  = !item_q.pos_x[POS_W-1] && (item_q.pos_x[BOX_W-1:0] <= box_x_q)
			&& !item_q.pos_y[POS_W-1] && (item_q.pos_y[BOX_W-1:0] <= box_y_q)
			&& !item_q.pos_z[POS_W-1] && (item_q.pos_z[BOX_W-1:0] <= box_z_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (accept) state_d = new_track ? ST_OUT : ST_SQR;
			ST_SQR:       if (ax_q == AXIS_Z) state_d = ST_SUM;
			ST_SUM:       state_d = ST_ROOT_GO;
			ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (sqrt_rsp.done) state_d = ST_PATH;
			ST_PATH:      state_d = step_bad ? ST_MEAN_CHK : ST_SPD_GO;
			ST_SPD_GO:    state_d = ST_SPD_WAIT;
			ST_SPD_WAIT:  if (div_rsp.done) state_d = ST_MEAN_CHK;
			ST_MEAN_CHK:  state_d = (elapsed == '0) ? ST_OUT : ST_MEAN_GO;
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_rsp.done) state_d = ST_OUT;
			ST_OUT:       if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		point_stall       = (state_q != ST_IDLE);
		out_load          = (state_q == ST_OUT) && (!result_valid_q || !result_stall);
		sqrt_cmd.go       = (state_q == ST_ROOT_GO);
		sqrt_cmd.radicand = sum_q;
		div_cmd.go        = 1'b0;
		div_cmd.dividend  = {length_q, {FRAC_W{1'b0}}};
		div_cmd.divisor   = elapsed;
		div_cmd.steps     = DIV_CNT_W'(MEAN_STEPS);
		case (state_q)
			ST_SPD_GO: begin
				div_cmd.go       = 1'b1;
				div_cmd.dividend = {seg_q, {(NUM_W-ROOT_W){1'b0}}};
				div_cmd.divisor  = dtu;
				div_cmd.steps    = DIV_CNT_W'(SPD_STEPS);
			end
			ST_MEAN_GO: begin
				div_cmd.go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			box_x_q <= BOX_RESET;
			box_y_q <= BOX_RESET;
			box_z_q <= BOX_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BOX_MAX_X: box_x_q <= cfg_data;
					CFG_BOX_MAX_Y: box_y_q <= cfg_data;
					CFG_BOX_MAX_Z: box_z_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			prev_stamp_q <= '0;
			first_q      <= '0;
			length_q     <= '0;
			peak_q       <= '0;
		end else begin
			// open a new track on the accepted point
			if (accept && new_track) begin
				length_q <= '0;
				peak_q   <= '0;
				first_q  <= point.stamp;
			end
			// add the segment, hold at the top
			if (state_q == ST_PATH) begin
				length_q <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
			end
			// keep the faster segment
			if ((state_q == ST_SPD_WAIT) && div_rsp.done && (div_rsp.quot > peak_q)) begin
				peak_q <= div_rsp.quot;
			end
			// advance the previous point
			if (out_load) begin
				have_prev_q  <= 1'b1;
				prev_x_q     <= item_q.pos_x;
				prev_y_q     <= item_q.pos_y;
				prev_z_q     <= item_q.pos_z;
				prev_stamp_q <= item_q.stamp;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= point;
			bad_q   <= 1'b0;
			mean_q  <= '0;
			ax_q    <= AXIS_X;
			prod_s1 <= '0;
			sum_q   <= '0;
		end
		// square one axis a cycle, sum the previous product
		if (state_q == ST_SQR) begin
			prod_s1 <= mag * mag;
			sum_q   <= sum_q + RAD_W'(prod_s1);
			ax_q    <= ax_q + 2'd1;
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_q + RAD_W'(prod_s1);
		end
		if ((state_q == ST_ROOT_WAIT) && sqrt_rsp.done) begin
			seg_q <= sqrt_rsp.root;
		end
		if (state_q == ST_PATH) begin
			bad_q <= step_bad;
		end
		if ((state_q == ST_MEAN_WAIT) && div_rsp.done) begin
			mean_q <= div_rsp.quot;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.visible     <= visible;
			result_q.path_length <= length_q;
			result_q.peak_speed  <= peak_q;
			result_q.mean_speed  <= mean_q;
			result_q.elapsed     <= elapsed;
			result_q.bad_step    <= bad_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/tlst_checker.sv =====
// ----------------------------------------------------------------------------
// tlst_checker: port-level checks of the track length and speed tracker
// Watches both channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module tlst_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                point_valid,
	input wire                point_stall,
	input wire                result_valid,
	input wire                result_stall,
	input tlst_pkg::result_t  result
);
	import tlst_pkg::*;

	// One point at a time: an accepted beat closes the input
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> point_stall)
		else $error("point accepted while previous point still in work");

	// No elapsed time, no mean speed
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.elapsed == '0) |-> (result.mean_speed == '0))
		else $error("mean speed reported with zero elapsed time");

	// No path, no mean speed
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.path_length == '0) |-> (result.mean_speed == '0))
		else $error("mean speed reported with zero path length");

	// A stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

endmodule

bind track_length_speed_tracker tlst_checker u_tlst_checker (.*);

`default_nettype wire

// ===== tb/track_length_speed_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// track_length_speed_tracker_tb: self-checking bench for the track tracker
// Runs a short table of hand-picked points (track openings, zero and negative
// time steps, stamp wrap, full-scale jumps, box edges), then random tracks
// under several box settings. Every accepted point runs through a local track
// predictor; beats are checked field by field against it or a typed result.
// ----------------------------------------------------------------------------

module track_length_speed_tracker_tb;

	import tlst_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_ITEMS = 275;
	localparam int unsigned SETTLE      = 200;
	localparam int unsigned PRINT_CAP   = 100;
	// index 3 decodes to no register; writes to it must be harmless
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		point_t  pt;
		bit      typed;
		result_t want;
	} probe_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 point_valid  = 1'b0;
	logic                 point_stall;
	point_t               point        = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_BOX_MAX_X;
	logic [BOX_W-1:0]     cfg_data     = '0;

	// predictor state: box limits and the open track
	logic [BOX_W-1:0]          lim_x = BOX_RESET;
	logic [BOX_W-1:0]          lim_y = BOX_RESET;
	logic [BOX_W-1:0]          lim_z = BOX_RESET;
	logic signed [POS_W-1:0]   last_x = '0;
	logic signed [POS_W-1:0]   last_y = '0;
	logic signed [POS_W-1:0]   last_z = '0;
	logic [STAMP_W-1:0]        last_stamp = '0;
	logic [STAMP_W-1:0]        origin_stamp = '0;
	logic [LEN_W-1:0]          run_length = '0;
	logic [SPD_W-1:0]          top_speed = '0;
	logic                      track_open = 1'b0;

	probe_row_t  script[$];
	result_t     reports_due[$];
	result_t     want_beat;
	int unsigned fault_count = 0;
	int unsigned beats_seen  = 0;
	int unsigned dead_cycles = 0;
	int unsigned stall_hold  = 0;
	bit          quiet       = 1'b0;

	track_length_speed_tracker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Track predictor
	// ------------------------------------------------------------------------

	function automatic logic [63:0] sq_gap(input logic signed [POS_W-1:0] a,
			input logic signed [POS_W-1:0] b);
		logic signed [POS_W:0] d;
		logic [POS_W:0]        u;
		logic [63:0]           m;
		d = {a[POS_W-1], a} - {b[POS_W-1], b};
		u = d[POS_W] ? (~d + 1'b1) : d;
		m = {{(64-POS_W-1){1'b0}}, u};
		return m * m;
	endfunction

	// bit-pair floor square root
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r   = '0;
		rem = n;
		b   = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit in_limit(input logic signed [POS_W-1:0] v,
			input logic [BOX_W-1:0] lim);
		return !v[POS_W-1] && (v[BOX_W-1:0] <= lim);
	endfunction

	// fold one point into the track and return its result beat
	function automatic result_t advance_track(input point_t p);
		result_t            r;
		logic [63:0]        seg;
		logic [63:0]        spd;
		logic [63:0]        mean;
		logic [STAMP_W-1:0] dt;
		logic [LEN_W:0]     acc;
		r = '0;
		if (p.start_track || !track_open) begin
			run_length   = '0;
			top_speed    = '0;
			origin_stamp = p.stamp;
		end else begin
			seg = floor_root(sq_gap(p.pos_x, last_x) + sq_gap(p.pos_y, last_y) +
					sq_gap(p.pos_z, last_z));
			dt  = p.stamp - last_stamp;
			acc = {1'b0, run_length} + seg[LEN_W:0];
			run_length = acc[LEN_W] ? LEN_MAX : acc[LEN_W-1:0];
			if (dt == 0 || dt[STAMP_W-1]) begin
				r.bad_step = 1'b1;
			end else begin
				spd = (seg << FRAC_W) / {32'd0, dt};
				if (spd > {32'd0, SPD_MAX})
					spd = {32'd0, SPD_MAX};
				if (spd[SPD_W-1:0] > top_speed)
					top_speed = spd[SPD_W-1:0];
			end
		end
		r.elapsed = p.stamp - origin_stamp;
		if (r.elapsed != 0) begin
			mean = ({24'd0, run_length} << FRAC_W) / {32'd0, r.elapsed};
			r.mean_speed = (mean > {32'd0, SPD_MAX}) ? SPD_MAX : mean[SPD_W-1:0];
		end
		last_x       = p.pos_x;
		last_y       = p.pos_y;
		last_z       = p.pos_z;
		last_stamp   = p.stamp;
		track_open   = 1'b1;
		r.visible    = in_limit(p.pos_x, lim_x) && in_limit(p.pos_y, lim_y) &&
				in_limit(p.pos_z, lim_z);
		r.path_length = run_length;
		r.peak_speed  = top_speed;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// mostly short pauses, now and then a long one
	function automatic int unsigned pause_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return $urandom_range(0, 2);
		if (pick < 90)
			return $urandom_range(3, 12);
		if (pick < 97)
			return $urandom_range(13, 40);
		return $urandom_range(60, 300);
	endfunction

	function automatic logic signed [POS_W-1:0] jitter(input int unsigned span);
		return POS_W'(int'($urandom_range(0, 2 * span)) - int'(span));
	endfunction

	// coordinates around the edges of the box on one axis
	function automatic logic signed [POS_W-1:0] probe_coord(input logic [BOX_W-1:0] lim);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return {1'b0, lim};
			2: return {1'b0, lim} + 1'b1;
			3: return '1;
			4: return POS_W'($urandom_range(0, lim));
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic point_t mk_point(input bit s, input int x, input int y, input int z,
			input logic [STAMP_W-1:0] t);
		point_t p;
		p.start_track = s;
		p.pos_x       = x[POS_W-1:0];
		p.pos_y       = y[POS_W-1:0];
		p.pos_z       = z[POS_W-1:0];
		p.stamp       = t;
		return p;
	endfunction

	function automatic result_t mk_result(input bit v, input logic [LEN_W-1:0] len,
			input logic [SPD_W-1:0] pk, input logic [SPD_W-1:0] mn,
			input logic [STAMP_W-1:0] el, input bit bad);
		result_t r;
		r.visible     = v;
		r.path_length = len;
		r.peak_speed  = pk;
		r.mean_speed  = mn;
		r.elapsed     = el;
		r.bad_step    = bad;
		return r;
	endfunction

	// append one row to the directed table
	task automatic add_row(input point_t pt, input bit typed, input result_t want);
		probe_row_t row;
		row.pt    = pt;
		row.typed = typed;
		row.want  = want;
		script.insert(script.size(), row);
	endtask

	task automatic fault(input string msg);
		fault_count++;
		if (fault_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// present one point beat, hold it until taken, then log its expectation
	task automatic offer_point(input point_t p, input bit use_typed, input result_t typed);
		int unsigned gap;
		result_t     calc;
		gap = quiet ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pause_length());
		if (gap != 0) begin
			point_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		point       = p;
		point_valid = 1'b1;
		do @(posedge clk); while (point_stall);
		calc = advance_track(p);
		reports_due.insert(reports_due.size(), use_typed ? typed : calc);
		@(negedge clk);
	endtask

	// hold off until every outstanding result has come back
	task automatic drain_results();
		point_valid = 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [BOX_W-1:0] v);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_BOX_MAX_X: lim_x = v;
			CFG_BOX_MAX_Y: lim_y = v;
			CFG_BOX_MAX_Z: lim_z = v;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall, checking, watchdog
	// ------------------------------------------------------------------------

	// stall the result channel in random runs; no new run starts while quiet
	always @(negedge clk) begin
		if (stall_hold != 0) begin
			stall_hold--;
		end else if (quiet) begin
			result_stall = 1'b0;
		end else begin
			result_stall = ($urandom_range(0, 2) == 0);
			stall_hold   = pause_length();
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (reports_due.size() == 0) begin
				fault($sformatf("result beat %0d arrived with nothing outstanding",
						beats_seen));
			end else begin
				want_beat = reports_due.pop_front();
				if (result.visible !== want_beat.visible)
					fault($sformatf("beat %0d visible %0b, want %0b", beats_seen,
							result.visible, want_beat.visible));
				if (result.path_length !== want_beat.path_length)
					fault($sformatf("beat %0d path_length %0d, want %0d", beats_seen,
							result.path_length, want_beat.path_length));
				if (result.peak_speed !== want_beat.peak_speed)
					fault($sformatf("beat %0d peak_speed %h, want %h", beats_seen,
							result.peak_speed, want_beat.peak_speed));
				if (result.mean_speed !== want_beat.mean_speed)
					fault($sformatf("beat %0d mean_speed %h, want %h", beats_seen,
							result.mean_speed, want_beat.mean_speed));
				if (result.elapsed !== want_beat.elapsed)
					fault($sformatf("beat %0d elapsed %h, want %h", beats_seen,
							result.elapsed, want_beat.elapsed));
				if (result.bad_step !== want_beat.bad_step)
					fault($sformatf("beat %0d bad_step %0b, want %0b", beats_seen,
							result.bad_step, want_beat.bad_step));
			end
			beats_seen++;
		end
	end

	// end the run when neither channel has moved for too long
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall))
			dead_cycles = 0;
		else
			dead_cycles++;
		if (dead_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin : stimulus
		point_t             p;
		result_t            none;
		logic [BOX_W-1:0]   lx;
		logic [BOX_W-1:0]   ly;
		logic [BOX_W-1:0]   lz;
		logic [STAMP_W-1:0] dt;
		int unsigned        style;
		int unsigned        span;
		int unsigned        dt_span;
		int unsigned        track_len;
		int unsigned        sent;
		int unsigned        pick;

		none = '0;

		// hand-picked points under the reset box; typed results where obvious
		add_row(mk_point(0, 0, 0, 0, 100), 1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(mk_point(0, 3, 4, 0, 101), 1,
				mk_result(1, 5, 327680, 327680, 1, 0));
		add_row(mk_point(0, 3, 4, 12, 101), 1,
				mk_result(1, 17, 327680, 1114112, 1, 1));
		add_row(mk_point(0, 3, 4, 12, 50), 1,
				mk_result(1, 17, 327680, 0, 32'hFFFF_FFCE, 1));
		add_row(mk_point(1, -8388608, -8388608, -8388608, 0), 1,
				mk_result(0, 0, 0, 0, 0, 0));
		add_row(mk_point(0, 8388607, 8388607, 8388607, 1), 0, none);
		add_row(mk_point(0, -8388608, 8388607, 8388607, 32'h8000_0001), 0, none);
		add_row(mk_point(0, -8388608, 8388607, 8388607, 32'h0000_0000), 0, none);
		add_row(mk_point(1, 0, 0, 0, 32'hFFFF_FFFF), 1,
				mk_result(1, 0, 0, 0, 0, 0));
		add_row(mk_point(0, 0, 0, 1, 0), 1, mk_result(1, 1, 65536, 65536, 1, 0));
		add_row(mk_point(0, 8388607, 0, 1, 1), 0, none);
		add_row(mk_point(0, 8388607, -1, 1, 2), 0, none);
		add_row(mk_point(1, 5, 6, 7, 1000), 1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(mk_point(1, 5, 6, 7, 1000), 1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(mk_point(0, 5, 6, 7, 1001), 1, mk_result(1, 0, 0, 0, 1, 0));
		add_row(mk_point(0, 8, 10, 7, 328681), 0, none);
		add_row(mk_point(0, 8388607, 8388607, 8388606, 328682), 0, none);
		add_row(mk_point(0, 8388607, 8388608, 0, 32'h7FFF_FFFF), 0, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i])
			offer_point(script[i].pt, script[i].typed, script[i].want);

		p = '0;
		for (int phase = 0; phase < PHASES; phase++) begin
			// change the box only once the block has gone idle
			if (phase != 0) begin
				drain_results();
				case (phase)
					1: begin
						lx = '0;
						ly = '0;
						lz = '0;
					end
					2: begin
						lx = BOX_RESET;
						ly = BOX_RESET;
						lz = BOX_RESET;
					end
					3: begin
						lx = BOX_RESET;
						ly = '0;
						lz = BOX_W'($urandom);
					end
					default: begin
						lx = BOX_W'($urandom);
						ly = BOX_W'($urandom_range(0, 4095));
						lz = BOX_W'($urandom);
					end
				endcase
				set_limit(CFG_BOX_MAX_X, lx);
				set_limit(CFG_BOX_MAX_Y, ly);
				set_limit(CFG_BOX_MAX_Z, lz);
				if (phase == 4)
					set_limit(CFG_SPARE, BOX_W'($urandom));
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				quiet = ($urandom_range(0, 9) == 0);
				style = $urandom_range(0, 9);
				pick  = $urandom_range(0, 15);
				track_len = (pick == 0) ? 1 :
						(pick < 13) ? $urandom_range(2, 12) : $urandom_range(13, 60);
				case ($urandom_range(0, 2))
					0: span = 7;
					1: span = 2000;
					default: span = 1 << 22;
				endcase
				case ($urandom_range(0, 2))
					0: dt_span = 4;
					1: dt_span = 5000;
					default: dt_span = 1 << 24;
				endcase
				p.pos_x = ($urandom_range(0, 1) == 0) ? POS_W'($urandom) :
						POS_W'($urandom_range(0, 1000));
				p.pos_y = POS_W'($urandom);
				p.pos_z = POS_W'($urandom_range(0, 1000));
				p.stamp = $urandom;

				for (int k = 0; k < track_len && sent < PHASE_ITEMS; k++) begin
					if ($urandom_range(0, 79) == 0)
						drain_results();
					if (style >= 8) begin
						// noise: every field at random
						p.start_track = 1'($urandom_range(0, 1));
						p.pos_x       = POS_W'($urandom);
						p.pos_y       = POS_W'($urandom);
						p.pos_z       = POS_W'($urandom);
						p.stamp       = $urandom;
					end else begin
						// a track: opened at its first point and now and then again; points move on or probe box edges
						p.start_track = (k == 0) || ($urandom_range(0, 39) == 0);
						if (style >= 6) begin
							p.pos_x = probe_coord(lim_x);
							p.pos_y = probe_coord(lim_y);
							p.pos_z = probe_coord(lim_z);
						end else begin
							p.pos_x = p.pos_x + jitter(span);
							p.pos_y = p.pos_y + jitter(span);
							p.pos_z = p.pos_z + jitter(span);
						end
						if ($urandom_range(0, 15) == 0)
							dt = ($urandom_range(0, 1) == 0) ? '0 : (32'h8000_0000 | $urandom);
						else
							dt = $urandom_range(1, dt_span);
						p.stamp = p.stamp + dt;
					end
					offer_point(p, 1'b0, none);
					sent++;
				end
			end
		end

		quiet = 1'b0;
		drain_results();
		repeat (SETTLE) @(negedge clk);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
